[design/bbc_pkg.sv]
// shared types and codes for the block buffer cache
`default_nettype none
package bbc_pkg;
  // pool geometry
  localparam int unsigned NUM_BUFFERS = 16;
  localparam int unsigned NUM_BUCKETS = 4;
  localparam int unsigned BLOCK_BITS  = 16;

  typedef enum logic [2:0] {
    CODE_HIT       = 3'd0,
    CODE_ALLOC     = 3'd1,
    CODE_BUSY      = 3'd2,
    CODE_NOFREE    = 3'd3,
    CODE_WRITEBACK = 3'd4,
    CODE_FULL      = 3'd5,
    CODE_RELEASED  = 3'd6,
    CODE_NOTHELD   = 3'd7
  } code_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_UPDATE,
    ST_DONE
  } state_e;

  localparam int unsigned OP_GET = 0;
  localparam int unsigned OP_RELEASE = 1;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic look;
    logic update;
    logic emit;
  } ctrl_t;
endpackage
`default_nettype wire

[design/bbc_ctrl.sv]
// controller state machine for the block buffer cache
`default_nettype none
module bbc_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  output logic                 busy,
  output bbc_pkg::ctrl_t       ctrl_o
);
  import bbc_pkg::*;

  state_e state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (start) state_d = ST_LOOK;
      ST_LOOK:   state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_DONE;
      ST_DONE:   state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctrl_o = '0;
    busy = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE:   ctrl_o.load = start;
      ST_LOOK:   ctrl_o.look = 1'b1;
      ST_UPDATE: ctrl_o.update = 1'b1;
      ST_DONE:   ctrl_o.emit = 1'b1;
      default:   ctrl_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end
endmodule
`default_nettype wire

[design/bbc_datapath.sv]
// tag store, free list and bucket counters of the block buffer cache
`default_nettype none
module bbc_datapath (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  bbc_pkg::ctrl_t      ctrl_i,
  input  wire logic           cfg_we_i,
  input  wire logic [4:0]     cfg_data_i,
  input  wire logic           op_i,
  input  wire logic [15:0]    block_i,
  input  wire logic [7:0]     owner_i,
  input  wire logic           delayed_write_i,
  output logic                valid_o,
  output logic [2:0]          code_o,
  output logic [3:0]          buffer_index_o,
  output logic [15:0]         writeback_block_o
);
  import bbc_pkg::*;

  localparam int IW = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
  localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int CW = $clog2(NUM_BUFFERS + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(NUM_BUFFERS);

  logic [4:0]            limit_q;
  logic [BLOCK_BITS-1:0] tag_q [NUM_BUFFERS];
  logic [NUM_BUFFERS-1:0] vld_q, bsy_q, dty_q;
  logic [7:0]            own_q [NUM_BUFFERS];
  logic [IW-1:0]         nxt_q [NUM_BUFFERS];
  logic [IW-1:0]         prv_q [NUM_BUFFERS];
  logic [IW-1:0]         head_q;
  logic [CW-1:0]         fcnt_q;
  logic [CW-1:0]         bcnt_q [NUM_BUCKETS];

  // captured request
  logic                  op_q, dw_q;
  logic [BLOCK_BITS-1:0] blk_q;
  logic [7:0]            ownr_q;
  // lookup results
  logic                  hit_q;
  logic [IW-1:0]         hidx_q;
  logic [2:0]            code_q;
  logic [3:0]            idx_q;
  logic [15:0]           wb_q;

  // parallel tag compare
  logic          hit_c;
  logic [IW-1:0] hidx_c;
  always_comb begin
    hit_c = 1'b0;
    hidx_c = '0;
    for (int i = NUM_BUFFERS - 1; i >= 0; i--) begin
      if (vld_q[i] && tag_q[i] == blk_q) begin
        hit_c = 1'b1;
        hidx_c = IW'(i);
      end
    end
  end

  logic [BW-1:0] nb, ob;
  assign nb = BW'(blk_q % NUM_BUCKETS);
  assign ob = BW'(tag_q[head_q] % NUM_BUCKETS);

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) limit_q <= 5'd5;
    else if (cfg_we_i) limit_q <= cfg_data_i;
  end

  // request capture and lookup
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      op_q <= op_i;
      dw_q <= delayed_write_i;
      blk_q <= block_i[BLOCK_BITS-1:0];
      ownr_q <= owner_i;
    end
    if (ctrl_i.look) begin
      hit_q <= hit_c;
      hidx_q <= hidx_c;
    end
  end

  // state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic [IW-1:0] x, p, n, t;
    logic [3:0]    ri;
    logic [15:0]   rw;
    if (!rst_ni) begin
      vld_q <= '0;
      bsy_q <= '0;
      dty_q <= '0;
      head_q <= '0;
      fcnt_q <= FULL_CNT;
      for (int i = 0; i < NUM_BUFFERS; i++) begin
        tag_q[i] <= '0;
        own_q[i] <= '0;
        nxt_q[i] <= IW'((i + 1) % NUM_BUFFERS);
        prv_q[i] <= IW'((i + NUM_BUFFERS - 1) % NUM_BUFFERS);
      end
      for (int b = 0; b < NUM_BUCKETS; b++) bcnt_q[b] <= '0;
      code_q <= CODE_HIT;
      idx_q <= '0;
      wb_q <= '0;
      valid_o <= 1'b0;
    end else begin
      valid_o <= ctrl_i.emit;
      if (ctrl_i.update) begin
        x = hit_q ? hidx_q : head_q;
        p = prv_q[x];
        n = nxt_q[x];
        t = prv_q[head_q];
        ri = '0;
        rw = '0;
        if (op_q == 1'(OP_GET)) begin
          if (hit_q) begin
            if (bsy_q[x]) code_q <= CODE_BUSY;
            else begin
              if (fcnt_q == CW'(1)) head_q <= '0;
              else begin
                nxt_q[p] <= n;
                prv_q[n] <= p;
                if (head_q == x) head_q <= n;
              end
              fcnt_q <= fcnt_q - CW'(1);
              bsy_q[x] <= 1'b1;
              own_q[x] <= ownr_q;
              code_q <= CODE_HIT;
              ri = 4'(x);
            end
          end else if (fcnt_q == '0) begin
            code_q <= CODE_NOFREE;
          end else if (dty_q[x]) begin
            dty_q[x] <= 1'b0;
            code_q <= CODE_WRITEBACK;
            ri = 4'(x);
            rw = 16'(tag_q[x]);
          end else if (32'(bcnt_q[nb]) >= 32'(limit_q)) begin
            code_q <= CODE_FULL;
          end else begin
            if (fcnt_q == CW'(1)) head_q <= '0;
            else begin
              nxt_q[p] <= n;
              prv_q[n] <= p;
              head_q <= n;
            end
            fcnt_q <= fcnt_q - CW'(1);
            if (vld_q[x] && bcnt_q[ob] != '0) begin
              if (ob == nb) bcnt_q[nb] <= bcnt_q[nb];
              else begin
                bcnt_q[ob] <= bcnt_q[ob] - CW'(1);
                bcnt_q[nb] <= bcnt_q[nb] + CW'(1);
              end
            end else bcnt_q[nb] <= bcnt_q[nb] + CW'(1);
            tag_q[x] <= blk_q;
            vld_q[x] <= 1'b1;
            bsy_q[x] <= 1'b1;
            dty_q[x] <= 1'b0;
            own_q[x] <= ownr_q;
            code_q <= CODE_ALLOC;
            ri = 4'(x);
          end
        end else begin
          if (hit_q && bsy_q[x]) begin
            dty_q[x] <= dty_q[x] | dw_q;
            bsy_q[x] <= 1'b0;
            if (fcnt_q == '0) begin
              head_q <= x;
              nxt_q[x] <= x;
              prv_q[x] <= x;
            end else begin
              nxt_q[t] <= x;
              prv_q[x] <= t;
              nxt_q[x] <= head_q;
              prv_q[head_q] <= x;
            end
            fcnt_q <= fcnt_q + CW'(1);
            code_q <= CODE_RELEASED;
            ri = 4'(x);
          end else code_q <= CODE_NOTHELD;
        end
        idx_q <= ri;
        wb_q <= rw;
      end
    end
  end

  assign code_o = code_q;
  assign buffer_index_o = idx_q;
  assign writeback_block_o = wb_q;
endmodule
`default_nettype wire

[design/block_buffer_cache_getblk.sv]
// top level of the block buffer cache
// A request beat (start high while busy low) is answered once by a one-cycle
// done_o strobe with the result on the result ports: the request is captured
// at its beat, the LOOK state registers the parallel tag compare, the UPDATE
// state updates the free list and counters, the DONE state arms the strobe,
// and the registered strobe shows the result after DONE. busy stays high in
// LOOK, UPDATE and DONE, so no new request is taken before the last leaves DONE.
// The receiver cannot stall; the result must be taken in its strobe cycle.
`default_nettype none
module block_buffer_cache_getblk (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        cfg_we_i,
  input  wire logic [4:0]  cfg_data_i,
  input  wire logic        op_i,
  input  wire logic [15:0] block_i,
  input  wire logic [7:0]  owner_i,
  input  wire logic        delayed_write_i,
  output logic             done_o,
  output logic [2:0]       code_o,
  output logic [3:0]       buffer_index_o,
  output logic [15:0]      writeback_block_o
);
  import bbc_pkg::*;

  ctrl_t ctrl;

  // controller
  bbc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .ctrl_o (ctrl)
  );

  // datapath
  bbc_datapath u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .ctrl_i            (ctrl),
    .cfg_we_i          (cfg_we_i),
    .cfg_data_i        (cfg_data_i),
    .op_i              (op_i),
    .block_i           (block_i),
    .owner_i           (owner_i),
    .delayed_write_i   (delayed_write_i),
    .valid_o           (done_o),
    .code_o            (code_o),
    .buffer_index_o    (buffer_index_o),
    .writeback_block_o (writeback_block_o)
  );
endmodule
`default_nettype wire

[tb/sv/block_buffer_cache_getblk_test.sv]
// self-checking testbench for the block buffer cache top level
`default_nettype none
module block_buffer_cache_getblk_test;
  import bbc_pkg::*;

  localparam int unsigned NBUF = 16;
  localparam int unsigned NBKT = 4;
  localparam logic [1:0] BUSY_BIT = 2'b01;
  localparam logic [1:0] DIRTY_BIT = 2'b10;

  typedef struct packed {
    code_e       code;
    logic [3:0]  index;
    logic [15:0] wb_block;
  } answer_t;

  // cache predictor and store of pending answers
  class cache_scoreboard;
    logic [4:0]  limit;
    logic [15:0] tag[NBUF];
    bit          bound[NBUF];
    logic [1:0]  status[NBUF];
    logic [7:0]  owner[NBUF];
    int unsigned nxt[NBUF];
    int unsigned prv[NBUF];
    int unsigned head;
    int unsigned nfree;
    int unsigned per_bucket[NBKT];
    answer_t     pending[$];
    int unsigned errors;

    function void clear();
      limit = 5'd5;
      for (int i = 0; i < NBUF; i++) begin
        tag[i] = '0;
        bound[i] = 0;
        status[i] = '0;
        owner[i] = '0;
        nxt[i] = (i + 1) % NBUF;
        prv[i] = (i + NBUF - 1) % NBUF;
      end
      foreach (per_bucket[b]) per_bucket[b] = 0;
      head = 0;
      nfree = NBUF;
      pending.delete();
      errors = 0;
    endfunction

    function void unlink(int unsigned x);
      int unsigned p, n;
      if (nfree == 0) return;
      if (nfree == 1) begin
        nfree = 0;
        head = 0;
        return;
      end
      p = prv[x];
      n = nxt[x];
      nxt[p] = n;
      prv[n] = p;
      if (head == x) head = n;
      nfree--;
    endfunction

    function void append(int unsigned x);
      int unsigned t;
      if (nfree == 0) begin
        head = x;
        nxt[x] = x;
        prv[x] = x;
      end else begin
        t = prv[head];
        nxt[t] = x;
        prv[x] = t;
        nxt[x] = head;
        prv[head] = x;
      end
      nfree++;
    endfunction

    // work out the answer to one accepted request beat
    function void note(logic op, logic [15:0] blk, logic [7:0] own, logic dw);
      answer_t a;
      int h;
      int unsigned x, b, ob;
      a = '{code: CODE_NOTHELD, index: '0, wb_block: '0};
      h = -1;
      for (int i = NBUF - 1; i >= 0; i--)
        if (bound[i] && tag[i] == blk) h = i;
      if (op == OP_GET[0]) begin
        if (h >= 0) begin
          if (status[h] & BUSY_BIT) a.code = CODE_BUSY;
          else begin
            unlink(h);
            status[h] |= BUSY_BIT;
            owner[h] = own;
            a.code = CODE_HIT;
            a.index = h[3:0];
          end
        end else if (nfree == 0) begin
          a.code = CODE_NOFREE;
        end else begin
          x = head;
          b = blk % NBKT;
          if (status[x] & DIRTY_BIT) begin
            status[x] &= ~DIRTY_BIT;
            a.code = CODE_WRITEBACK;
            a.index = x[3:0];
            a.wb_block = tag[x];
          end else if (per_bucket[b] >= limit) begin
            a.code = CODE_FULL;
          end else begin
            unlink(x);
            if (bound[x]) begin
              ob = tag[x] % NBKT;
              if (per_bucket[ob] > 0) per_bucket[ob]--;
            end
            tag[x] = blk;
            bound[x] = 1;
            status[x] = BUSY_BIT;
            owner[x] = own;
            per_bucket[b]++;
            a.code = CODE_ALLOC;
            a.index = x[3:0];
          end
        end
      end else if (h >= 0 && (status[h] & BUSY_BIT)) begin
        status[h] = (status[h] & DIRTY_BIT) | (dw ? DIRTY_BIT : 2'b00);
        append(h);
        a.code = CODE_RELEASED;
        a.index = h[3:0];
      end
      pending.push_back(a);
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
    endtask

    // compare one result beat with the oldest pending answer
    task check(logic [2:0] code, logic [3:0] idx, logic [15:0] wb);
      answer_t a;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result code %0d", code));
        return;
      end
      a = pending.pop_front();
      if (code !== a.code)
        report($sformatf("code %0d, want %0d", code, a.code));
      if (idx !== a.index)
        report($sformatf("buffer index %0d, want %0d", idx, a.index));
      if (wb !== a.wb_block)
        report($sformatf("writeback block %h, want %h", wb, a.wb_block));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        cfg_we_i = 1'b0;
  logic [4:0]  cfg_data_i = '0;
  logic        op_i = 1'b0;
  logic [15:0] block_i = '0;
  logic [7:0]  owner_i = '0;
  logic        delayed_write_i = 1'b0;
  logic        done_o;
  logic [2:0]  code_o;
  logic [3:0]  buffer_index_o;
  logic [15:0] writeback_block_o;

  cache_scoreboard sb = new();
  logic [15:0] hot_blocks[24];
  int unsigned beat_no = 0;

  block_buffer_cache_getblk u_dut (
    .clk_i, .rst_ni, .start, .busy, .cfg_we_i, .cfg_data_i,
    .op_i, .block_i, .owner_i, .delayed_write_i,
    .done_o, .code_o, .buffer_index_o, .writeback_block_o
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // result beats are taken at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check(code_o, buffer_index_o, writeback_block_o);
  end

  // present one request and hold it until a beat is taken
  task send(logic op, logic [15:0] blk, logic [7:0] own, logic dw, bit gaps);
    if (gaps && $urandom_range(99) < 11) begin
      start <= 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk_i);
    end
    start <= 1'b1;
    op_i <= op;
    block_i <= blk;
    owner_i <= own;
    delayed_write_i <= dw;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    sb.note(op, blk, own, dw);
    beat_no++;
    @(negedge clk_i);
  endtask

  // drain, then write the bucket limit while the block sits idle
  task set_limit(logic [4:0] lim);
    start <= 1'b0;
    @(negedge clk_i);
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= lim;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.limit = lim;
  endtask

  task random_phase(int unsigned count);
    logic [15:0] blk;
    foreach (hot_blocks[k]) hot_blocks[k] = 16'($urandom);
    for (int unsigned n = 0; n < count; n++) begin
      if ($urandom_range(99) < 85) blk = hot_blocks[$urandom_range(23)];
      else blk = 16'($urandom);
      send(1'($urandom), blk, 8'($urandom), 1'($urandom),
           !(beat_no >= 500 && beat_no < 800));
    end
  endtask

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    sb.clear();
    @(negedge clk_i);
    // directed: bucket filling, busy, dirty hit, not held, field extremes
    send(OP_GET[0], 16'd0, 8'd0, 1'b0, 0);
    send(OP_GET[0], 16'd4, 8'd255, 1'b0, 0);
    send(OP_GET[0], 16'd8, 8'd1, 1'b0, 0);
    send(OP_GET[0], 16'd12, 8'd2, 1'b0, 0);
    send(OP_GET[0], 16'd16, 8'd3, 1'b0, 0);
    send(OP_GET[0], 16'd20, 8'd4, 1'b0, 0);
    send(OP_GET[0], 16'd0, 8'd5, 1'b0, 0);
    send(OP_RELEASE[0], 16'd0, 8'd0, 1'b1, 0);
    send(OP_RELEASE[0], 16'd0, 8'd0, 1'b0, 0);
    send(OP_GET[0], 16'hFFFF, 8'hAA, 1'b0, 0);
    send(OP_RELEASE[0], 16'hFFFF, 8'h55, 1'b1, 0);
    send(OP_GET[0], 16'd0, 8'd9, 1'b0, 0);
    send(OP_RELEASE[0], 16'd0, 8'd9, 1'b0, 0);
    send(OP_RELEASE[0], 16'h1234, 8'd0, 1'b0, 0);
    send(OP_RELEASE[0], 16'd4, 8'd0, 1'b1, 0);
    for (int k = 0; k < 10; k++) send(OP_GET[0], 16'(k * 7 + 101), 8'(k), 1'b0, 0);
    random_phase(400);
    set_limit(5'd1);
    random_phase(200);
    set_limit(5'd16);
    random_phase(400);
    set_limit(5'd0);
    random_phase(60);
    set_limit(5'd31);
    random_phase(100);
    set_limit(5'd3);
    random_phase(200);
    start <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (sb.errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #200000;
    $display("Verification failed");
    $finish;
  end
endmodule
`default_nettype wire
